/* hdl/ppsup_pkg.sv */
// ----------------------------------------------------------------------------
// ppsup_pkg
// Types and constants shared by the pump pressure supervisor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ppsup_pkg;

   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_LOW_PRESSURE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_PRESSURE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_RUNTIME   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SUSPEND_SECS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_TEMP      = 3'd4;

   localparam logic [11:0] LOW_PRESSURE_RST  = 12'd250;
   localparam logic [11:0] HIGH_PRESSURE_RST = 12'd400;
   localparam logic [15:0] MAX_RUNTIME_RST   = 16'd600;
   localparam logic [15:0] SUSPEND_SECS_RST  = 16'd600;
   localparam logic [12:0] MIN_TEMP_RST      = 13'd30;

   localparam logic [1:0] MODE_ALARM   = 2'd0;
   localparam logic [1:0] MODE_SECOND  = 2'd1;
   localparam logic [1:0] MODE_CONTROL = 2'd2;

   localparam logic [9:0] TEMP_RAW_MIN = 10'd350;
   localparam logic [9:0] TEMP_RAW_MAX = 10'd700;

   // alarm flag bit positions
   localparam int FLAG_SENSOR  = 0;
   localparam int FLAG_COLD    = 1;
   localparam int FLAG_RUNTIME = 2;
   localparam int FLAG_MEMORY  = 3;

   typedef struct packed {
      logic [11:0]        low_pressure;
      logic [11:0]        high_pressure;
      logic [15:0]        max_runtime_seconds;
      logic [15:0]        suspend_seconds;
      logic signed [12:0] min_temperature;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [11:0]        pressure_value;
      logic [9:0]         pressure_raw_average;
      logic [9:0]         temp_raw_average;
      logic signed [12:0] temperature_value;
      logic               mem_short;
      logic               sensors_ready;
      logic               updating;
   } req_item_type;

   typedef struct packed {
      logic        pump_on;
      logic        suspended;
      logic        sensor_alarm;
      logic        cold_alarm;
      logic        runtime_alarm;
      logic        memory_alarm;
      logic [31:0] seconds_in_state;
      logic [15:0] start_total;
      logic [15:0] suspension_total;
   } rsp_item_type;

endpackage

`default_nettype wire

/* hdl/ppsup_csr.sv */
// ----------------------------------------------------------------------------
// ppsup_csr
// Threshold and timing registers, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsup_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [ppsup_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ppsup_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output ppsup_pkg::cfg_type                    cfg
);
   import ppsup_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_LOW_PRESSURE:  cfg_in.low_pressure        = csr_wdata[11:0];
            REG_HIGH_PRESSURE: cfg_in.high_pressure       = csr_wdata[11:0];
            REG_MAX_RUNTIME:   cfg_in.max_runtime_seconds = csr_wdata[15:0];
            REG_SUSPEND_SECS:  cfg_in.suspend_seconds     = csr_wdata[15:0];
            REG_MIN_TEMP:      cfg_in.min_temperature     = $signed(csr_wdata[12:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_pressure        <= LOW_PRESSURE_RST;
         cfg_ff.high_pressure       <= HIGH_PRESSURE_RST;
         cfg_ff.max_runtime_seconds <= MAX_RUNTIME_RST;
         cfg_ff.suspend_seconds     <= SUSPEND_SECS_RST;
         cfg_ff.min_temperature     <= $signed(MIN_TEMP_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hdl/ppsup_core.sv */
// ----------------------------------------------------------------------------
// ppsup_core
// Pump state, alarm flags and suspension timer, updated once per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsup_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  ppsup_pkg::req_item_type     item,
   input  ppsup_pkg::cfg_type          cfg,
   output ppsup_pkg::rsp_item_type     result
);
   import ppsup_pkg::*;

   logic        running_ff,     running_in;
   logic [31:0] age_ff,         age_in;
   logic [15:0] starts_ff,      starts_in;
   logic [15:0] timer_ff,       timer_in;
   logic [15:0] suspensions_ff, suspensions_in;
   logic [3:0]  flags_ff,       flags_in;

   logic       sens;
   logic       cold;
   logic       rt;
   logic [3:0] flags_alarm;
   logic       request;

   assign sens = (item.temp_raw_average < TEMP_RAW_MIN) ||
                 (item.temp_raw_average > TEMP_RAW_MAX) ||
                 (item.pressure_raw_average == 10'd0);
   assign cold = $signed(item.temperature_value) < $signed(cfg.min_temperature);
   assign rt   = running_ff && (age_ff > {16'd0, cfg.max_runtime_seconds});

   assign flags_alarm = {item.mem_short,
                         item.updating ? flags_ff[2:0] : {rt, cold, sens}};
   assign request     = |(flags_ff & ~flags_alarm);

   always_comb begin
      running_in     = running_ff;
      age_in         = age_ff;
      starts_in      = starts_ff;
      timer_in       = timer_ff;
      suspensions_in = suspensions_ff;
      flags_in       = flags_ff;
      if (step_en && item.sensors_ready) begin
         case (item.mode)
            MODE_ALARM: begin
               flags_in = flags_alarm;
               if (flags_alarm == 4'd0) begin
                  if (request) begin
                     timer_in       = 16'd1;
                     suspensions_in = suspensions_ff + 16'd1;
                  end else if (timer_ff >= cfg.suspend_seconds) begin
                     timer_in = 16'd0;
                  end
               end
            end
            MODE_SECOND: begin
               age_in = age_ff + 32'd1;
               if (flags_ff == 4'd0 && timer_ff != 16'd0 &&
                   timer_ff < cfg.suspend_seconds) begin
                  timer_in = timer_ff + 16'd1;
               end
            end
            MODE_CONTROL: begin
               if (!running_ff) begin
                  if (item.pressure_value <= cfg.low_pressure &&
                      item.pressure_raw_average != 10'd0 && flags_ff == 4'd0 &&
                      (timer_ff == 16'd0 || timer_ff > cfg.suspend_seconds)) begin
                     running_in = 1'b1;
                     age_in     = 32'd0;
                     starts_in  = starts_ff + 16'd1;
                  end
               end else if (item.pressure_value >= cfg.high_pressure ||
                            flags_ff != 4'd0) begin
                  running_in = 1'b0;
                  age_in     = 32'd0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         age_ff         <= 32'd0;
         starts_ff      <= 16'd0;
         timer_ff       <= 16'd0;
         suspensions_ff <= 16'd0;
         flags_ff       <= 4'd0;
      end else begin
         running_ff     <= running_in;
         age_ff         <= age_in;
         starts_ff      <= starts_in;
         timer_ff       <= timer_in;
         suspensions_ff <= suspensions_in;
         flags_ff       <= flags_in;
      end
   end

   always_comb begin
      result.pump_on          = running_in;
      result.suspended        = (timer_in != 16'd0);
      result.sensor_alarm     = flags_in[FLAG_SENSOR];
      result.cold_alarm       = flags_in[FLAG_COLD];
      result.runtime_alarm    = flags_in[FLAG_RUNTIME];
      result.memory_alarm     = flags_in[FLAG_MEMORY];
      result.seconds_in_state = age_in;
      result.start_total      = starts_in;
      result.suspension_total = suspensions_in;
   end

endmodule

`default_nettype wire

/* hdl/pump_pressure_supervisor_top.sv */
// ----------------------------------------------------------------------------
// pump_pressure_supervisor_top
// Pressure-band pump supervisor with alarm, second and control ticks.
//
//   channel | direction | transfer when
//   req_    | in        | req_tvalid & req_tready
//   rsp_    | out       | rsp_tvalid & rsp_tready
//   csr_    | in        | csr_we
//
// One tick per cycle sustained while rsp_tready stays high.
// A tick passes through the input register, the state update and the output register.
// While a result waits on rsp_tready the input register takes at most one
// tick, then req_tready drops until the result moves on.
// Reset is synchronous; it clears the valid flags, state and thresholds and
// holds req_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module pump_pressure_supervisor_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // pressure_value, pressure_raw_average, temp_raw_average, temperature_value,
   // mem_short, sensors_ready, updating
   input  wire logic [ppsup_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // mode
   input  wire logic [ppsup_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // pump_on, suspended, sensor_alarm, cold_alarm, runtime_alarm, memory_alarm,
   // seconds_in_state, start_total, suspension_total, zero fill
   output      logic [ppsup_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [ppsup_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ppsup_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ppsup_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item_ff;
   rsp_item_type result;
   rsp_item_type out_ff;
   logic         in_valid_ff, in_valid_in;
   logic         out_valid_ff, out_valid_in;
   logic         advance;
   logic         step_en;
   logic         req_fire;

   assign req_item.mode                 = req_tuser;
   assign req_item.pressure_value       = req_tdata[11:0];
   assign req_item.pressure_raw_average = req_tdata[21:12];
   assign req_item.temp_raw_average     = req_tdata[31:22];
   assign req_item.temperature_value    = $signed(req_tdata[44:32]);
   assign req_item.mem_short            = req_tdata[45];
   assign req_item.sensors_ready        = req_tdata[46];
   assign req_item.updating             = req_tdata[47];

   assign advance    = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && advance;
   assign req_tready = !reset && (!in_valid_ff || advance);
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   ppsup_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppsup_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item;
      end
      if (step_en) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_ff.suspension_total,
                        out_ff.start_total,
                        out_ff.seconds_in_state,
                        out_ff.memory_alarm,
                        out_ff.runtime_alarm,
                        out_ff.cold_alarm,
                        out_ff.sensor_alarm,
                        out_ff.suspended,
                        out_ff.pump_on};

endmodule

`default_nettype wire

/* hdl/ppsup_checker.sv */
// ----------------------------------------------------------------------------
// ppsup_checker
// Port-level checks on results of the pump pressure supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsup_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [ppsup_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ppsup_pkg::*;

   logic        prev_valid_ff, prev_valid_in;
   logic [15:0] prev_starts_ff;
   logic [15:0] prev_susp_ff;
   logic        rsp_fire;
   logic [15:0] cur_starts;
   logic [15:0] cur_susp;
   logic        start_step;
   logic        susp_step;

   assign rsp_fire      = rsp_tvalid && rsp_tready;
   assign cur_starts    = rsp_tdata[53:38];
   assign cur_susp      = rsp_tdata[69:54];
   assign prev_valid_in = prev_valid_ff || rsp_fire;
   assign start_step    = rsp_fire && prev_valid_ff && (cur_starts != prev_starts_ff);
   assign susp_step     = rsp_fire && prev_valid_ff && (cur_susp != prev_susp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
      end else begin
         prev_valid_ff <= prev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         prev_starts_ff <= cur_starts;
         prev_susp_ff   <= cur_susp;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_start_count: assert property (@(posedge clock) disable iff (reset)
      start_step |-> cur_starts == prev_starts_ff + 16'd1 &&
                     rsp_tdata[0] && rsp_tdata[37:6] == 32'd0)
      else $error("start count moved without a fresh pump start");

   a_susp_count: assert property (@(posedge clock) disable iff (reset)
      susp_step |-> cur_susp == prev_susp_ff + 16'd1 &&
                    rsp_tdata[1] && rsp_tdata[5:2] == 4'd0)
      else $error("suspension count moved without an alarm-free suspension");

endmodule

bind pump_pressure_supervisor_top ppsup_checker u_ppsup_checker (.*);

`default_nettype wire

/* test/tb_pump_pressure_supervisor_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pump_pressure_supervisor_top
// Drives alarm, second and control ticks into the pump supervisor under
// several threshold settings, predicts the pump, alarm and suspension state
// after every tick and compares each transfer on the result stream.
// ----------------------------------------------------------------------------
module tb_pump_pressure_supervisor_top;
   import ppsup_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 8;
   localparam int PHASE_TICKS = 205;

   class pump_scoreboard;
      logic [11:0]        low_p, high_p;
      logic [15:0]        max_rt, susp_len;
      logic signed [12:0] min_temp;
      bit                 running;
      bit [31:0]          age, run_secs, susp_secs_total;
      bit [15:0]          starts, susp_timer, susp_count;
      bit [3:0]           flags;
      rsp_item_type       expected_q[$];
      int                 errors, checked, n_starts, n_suspend, n_rt_alarm;

      function new();
         low_p = LOW_PRESSURE_RST;
         high_p = HIGH_PRESSURE_RST;
         max_rt = MAX_RUNTIME_RST;
         susp_len = SUSPEND_SECS_RST;
         min_temp = MIN_TEMP_RST;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_LOW_PRESSURE:  low_p = val[11:0];
            REG_HIGH_PRESSURE: high_p = val[11:0];
            REG_MAX_RUNTIME:   max_rt = val;
            REG_SUSPEND_SECS:  susp_len = val;
            REG_MIN_TEMP:      min_temp = val[12:0];
            default: ;
         endcase
      endfunction

      function void alarm_tick(req_item_type t);
         bit [3:0] old, f;
         logic signed [12:0] temp_now;
         bit request;
         old = flags;
         f = old;
         f[FLAG_MEMORY] = t.mem_short;
         if (!t.updating) begin
            temp_now = t.temperature_value;
            f[FLAG_SENSOR] = t.temp_raw_average < TEMP_RAW_MIN ||
                             t.temp_raw_average > TEMP_RAW_MAX ||
                             t.pressure_raw_average == 0;
            f[FLAG_COLD] = temp_now < min_temp;
            f[FLAG_RUNTIME] = running && age > max_rt;
         end
         if (f[FLAG_RUNTIME] && !old[FLAG_RUNTIME]) n_rt_alarm++;
         request = (old & ~f) != 0;
         flags = f;
         if (flags == 0) begin
            if (request) begin
               susp_timer = 1;
               susp_count++;
               n_suspend++;
            end else if (susp_timer >= susp_len) begin
               susp_timer = 0;
            end
         end
      endfunction

      function void second_tick();
         age++;
         if (running) run_secs++;
         if (flags == 0 && susp_timer > 0 && susp_timer < susp_len) begin
            susp_timer++;
            susp_secs_total++;
         end
      endfunction

      function void control_tick(req_item_type t);
         if (!running) begin
            if (t.pressure_value <= low_p && t.pressure_raw_average > 0 && flags == 0 &&
                (susp_timer == 0 || susp_timer > susp_len)) begin
               running = 1;
               age = 0;
               starts++;
               n_starts++;
            end
         end else if (t.pressure_value >= high_p || flags != 0) begin
            running = 0;
            age = 0;
         end
      endfunction

      function void note_tick(req_item_type t);
         rsp_item_type e;
         if (t.sensors_ready) begin
            case (t.mode)
               MODE_ALARM:   alarm_tick(t);
               MODE_SECOND:  second_tick();
               MODE_CONTROL: control_tick(t);
               default: ;
            endcase
         end
         e.pump_on = running;
         e.suspended = susp_timer != 0;
         e.sensor_alarm = flags[FLAG_SENSOR];
         e.cold_alarm = flags[FLAG_COLD];
         e.runtime_alarm = flags[FLAG_RUNTIME];
         e.memory_alarm = flags[FLAG_MEMORY];
         e.seconds_in_state = age;
         e.start_total = starts;
         e.suspension_total = susp_count;
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] raw);
         rsp_item_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result transfer with no tick waiting, actual %h", $time, raw);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         compare_field("pump_on", 32'(e.pump_on), 32'(raw[0]));
         compare_field("suspended", 32'(e.suspended), 32'(raw[1]));
         compare_field("sensor_alarm", 32'(e.sensor_alarm), 32'(raw[2]));
         compare_field("cold_alarm", 32'(e.cold_alarm), 32'(raw[3]));
         compare_field("runtime_alarm", 32'(e.runtime_alarm), 32'(raw[4]));
         compare_field("memory_alarm", 32'(e.memory_alarm), 32'(raw[5]));
         compare_field("seconds_in_state", e.seconds_in_state, raw[37:6]);
         compare_field("start_total", 32'(e.start_total), 32'(raw[53:38]));
         compare_field("suspension_total", 32'(e.suspension_total), 32'(raw[69:54]));
      endfunction

      function int waiting();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pump_scoreboard sb = new();
   bit steady;
   int fault_pct;
   int tick_count;
   int settings_count;
   int cycle_count;

   pump_pressure_supervisor_top dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_pump_pressure_supervisor_top: FAIL");
         $finish;
      end
   end

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= steady || ($urandom_range(99) >= 24);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   function automatic req_item_type make_tick(logic [1:0] md, int p, int praw, int traw,
                                              int temp, bit mem, bit rdy, bit upd);
      req_item_type t;
      t.mode = md;
      t.pressure_value = 12'(p);
      t.pressure_raw_average = 10'(praw);
      t.temp_raw_average = 10'(traw);
      t.temperature_value = 13'(temp);
      t.mem_short = mem;
      t.sensors_ready = rdy;
      t.updating = upd;
      return t;
   endfunction

   function automatic req_item_type random_tick();
      req_item_type t;
      logic [49:0] noise;
      int pick, lo;
      if ($urandom_range(99) < 12) begin
         noise = 50'({$urandom(), $urandom()});
         t = noise;
         return t;
      end
      pick = $urandom_range(99);
      t.mode = pick < 35 ? MODE_ALARM : (pick < 70 ? MODE_SECOND : MODE_CONTROL);
      t.sensors_ready = $urandom_range(99) < 95;
      t.updating = $urandom_range(99) < 5;
      t.mem_short = $urandom_range(99) < fault_pct / 3;
      t.temp_raw_average = 10'($urandom_range(99) < fault_pct ? $urandom_range(1023)
                                                              : $urandom_range(700, 350));
      t.pressure_raw_average = 10'($urandom_range(99) < fault_pct / 2 ? 0
                                                                     : $urandom_range(1023, 1));
      lo = int'(sb.min_temp);
      if (lo > -2732 && $urandom_range(99) < fault_pct)
         t.temperature_value = 13'(lo - 1 - int'($urandom_range(lo + 2731)));
      else
         t.temperature_value = 13'(lo + int'($urandom_range(2300 - lo)));
      pick = $urandom_range(99);
      if (pick < 40) t.pressure_value = 12'($urandom_range(sb.low_p));
      else if (pick < 70) t.pressure_value = 12'($urandom_range(4095, sb.high_p));
      else t.pressure_value = 12'($urandom_range(4095));
      return t;
   endfunction

   task automatic send_tick(input req_item_type t);
      while (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= t.mode;
      req_tdata <= {t.updating, t.sensors_ready, t.mem_short, t.temperature_value,
                    t.temp_raw_average, t.pressure_raw_average, t.pressure_value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(t);
      tick_count++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      write_reg(REG_LOW_PRESSURE, {4'd0, c.low_pressure});
      write_reg(REG_HIGH_PRESSURE, {4'd0, c.high_pressure});
      write_reg(REG_MAX_RUNTIME, c.max_runtime_seconds);
      write_reg(REG_SUSPEND_SECS, c.suspend_seconds);
      write_reg(REG_MIN_TEMP, {{3{c.min_temperature[12]}}, c.min_temperature});
      csr_we <= 1'b0;
      settings_count++;
   endtask

   initial begin
      req_item_type directed[$];
      cfg_type c;
      int ph, i;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      steady = 0;
      fault_pct = 10;
      settings_count = 1;
      cycle_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: low 250, high 400, limit 30 tenths
      directed.push_back(make_tick(MODE_CONTROL, 0, 500, 500, 200, 0, 0, 0));
      directed.push_back(make_tick(MODE_UNUSED, 0, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_ALARM, 300, 1, 350, 30, 0, 1, 0));
      directed.push_back(make_tick(MODE_CONTROL, 0, 0, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_CONTROL, 251, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_CONTROL, 250, 1023, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_SECOND, 300, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_SECOND, 300, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_CONTROL, 399, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_CONTROL, 400, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_CONTROL, 0, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_ALARM, 300, 500, 349, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_CONTROL, 0, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_ALARM, 4095, 1023, 701, 2300, 0, 1, 0));
      directed.push_back(make_tick(MODE_ALARM, 300, 0, 700, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_ALARM, 300, 500, 500, 200, 1, 1, 1));
      directed.push_back(make_tick(MODE_ALARM, 300, 500, 500, 29, 0, 1, 0));
      directed.push_back(make_tick(MODE_ALARM, 300, 500, 500, -2732, 0, 1, 0));
      directed.push_back(make_tick(MODE_ALARM, 300, 500, 500, 30, 0, 1, 0));
      directed.push_back(make_tick(MODE_CONTROL, 0, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_SECOND, 300, 500, 500, 200, 0, 1, 0));
      directed.push_back(make_tick(MODE_CONTROL, 4095, 500, 500, 200, 0, 1, 0));
      foreach (directed[k]) send_tick(directed[k]);

      for (ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: begin
               c.low_pressure = 12'd4095;
               c.high_pressure = 12'd4095;
               c.max_runtime_seconds = 16'd65535;
               c.suspend_seconds = 16'd65535;
               c.min_temperature = 13'sd2300;
            end
            1: begin
               c.low_pressure = 12'd0;
               c.high_pressure = 12'd0;
               c.max_runtime_seconds = 16'd0;
               c.suspend_seconds = 16'd0;
               c.min_temperature = -13'sd2732;
            end
            default: begin
               c.low_pressure = 12'($urandom_range(3000, 50));
               c.high_pressure = 12'($urandom_range(99) < 20 ? $urandom_range(4095)
                                     : c.low_pressure + $urandom_range(1000, 1));
               c.max_runtime_seconds = 16'($urandom_range(12));
               c.suspend_seconds = 16'($urandom_range(10));
               c.min_temperature = 13'(-2732 + int'($urandom_range(5032)));
            end
         endcase
         apply_settings(c);
         steady = (ph == 4);
         fault_pct = ph < 2 ? 10 : $urandom_range(15, 2);
         for (i = 0; i < PHASE_TICKS; i++) begin
            // in phase 3, hold until the result stream is empty once mid-phase
            if (ph == 3 && i == PHASE_TICKS / 2) wait_drained();
            send_tick(random_tick());
         end
      end
      steady = 0;
      wait_drained();
      repeat (8) @(posedge clock);

      $display("%0d ticks under %0d threshold settings, %0d results checked",
               tick_count, settings_count, sb.checked);
      $display("pump starts %0d, suspensions %0d, runtime alarms raised %0d",
               sb.n_starts, sb.n_suspend, sb.n_rt_alarm);
      if (sb.errors == 0 && sb.waiting() == 0)
         $display("tb_pump_pressure_supervisor_top: PASS");
      else
         $display("tb_pump_pressure_supervisor_top: FAIL");
      $finish;
   end

endmodule
